### rtl/cpu_bus_decode_ram_stack_macros.svh
// Assertion macros shared by the RTL of the bus decoder and stack block.
`ifndef CPU_BUS_DECODE_RAM_STACK_MACROS_SVH
`define CPU_BUS_DECODE_RAM_STACK_MACROS_SVH

// same-cycle implication, disabled during reset
`define CBDRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CBDRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/cbdrs_pkg.sv
// Types, codes and address decode shared by the bus decoder and stack block.
`timescale 1ns / 1ps
package cbdrs_pkg;

	localparam logic [2:0] MODE_READ      = 3'd0;
	localparam logic [2:0] MODE_WRITE     = 3'd1;
	localparam logic [2:0] MODE_PUSH_BYTE = 3'd2;
	localparam logic [2:0] MODE_POP_BYTE  = 3'd3;
	localparam logic [2:0] MODE_PUSH_WORD = 3'd4;
	localparam logic [2:0] MODE_POP_WORD  = 3'd5;

	localparam logic [2:0] TGT_RAM     = 3'd0;
	localparam logic [2:0] TGT_PICTURE = 3'd1;
	localparam logic [2:0] TGT_DMA     = 3'd2;
	localparam logic [2:0] TGT_CTRL    = 3'd3;
	localparam logic [2:0] TGT_CART    = 3'd4;
	localparam logic [2:0] TGT_IGNORED = 3'd5;

	localparam logic [15:0] ADDR_PICTURE  = 16'h2000;
	localparam logic [15:0] ADDR_IO       = 16'h4000;
	localparam logic [15:0] ADDR_DMA      = 16'h4014;
	localparam logic [15:0] ADDR_CTRL     = 16'h4016;
	localparam logic [15:0] ADDR_CTRL2    = 16'h4017;
	localparam logic [15:0] ADDR_IO_END   = 16'h4020;
	localparam logic [15:0] ADDR_CART     = 16'h6000;
	localparam logic [4:0]  STACK_PAGE_HI = 5'b00001;

	typedef struct packed {
		logic [2:0]  tgt;
		logic [15:0] dev;
		logic        err;
	} route_t;

	function automatic route_t route(input logic [15:0] a, input logic is_write);
		route_t r;
		r.tgt = TGT_IGNORED;
		r.dev = a;
		r.err = 1'b0;
		if (a < ADDR_PICTURE) begin
			r.tgt = TGT_RAM;
		end else if (a < ADDR_IO) begin
			r.tgt = TGT_PICTURE;
			r.dev = {ADDR_PICTURE[15:3], a[2:0]};
		end else if (a == ADDR_DMA) begin
			r.tgt = TGT_DMA;
		end else if (a == ADDR_CTRL) begin
			r.tgt = TGT_CTRL;
		end else if (!is_write && a == ADDR_CTRL2) begin
			r.tgt = TGT_IGNORED;
		end else if (is_write && a < ADDR_IO_END) begin
			r.tgt = TGT_IGNORED;
		end else if (a >= ADDR_CART) begin
			r.tgt = TGT_CART;
		end else begin
			r.err = 1'b1;
		end
		return r;
	endfunction

endpackage

### rtl/cbdrs_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module cbdrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### rtl/cpu_bus_decode_ram_stack.sv
// Top level: bus address decode, internal RAM access and stack push/pop.
// Byte requests and unknown modes pass through ST_B before done strobes; word push/pop pass through ST_W1, then ST_B.
// A new request is accepted only while busy is low; the single RAM port
// serializes the two byte accesses of a word request.
// busy drops in the cycle the result is strobed, so the next request overlaps it.
// After reset the RAM is cleared one entry a cycle; busy stays high until every entry is cleared.
`timescale 1ns / 1ps
`include "cpu_bus_decode_ram_stack_macros.svh"
module cpu_bus_decode_ram_stack #(
	parameter int RAM_DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [15:0] address,
	input  logic [15:0] data,
	input  logic [7:0]  stack_pointer,
	output logic        done,
	output logic [15:0] read_data,
	output logic [2:0]  target,
	output logic [15:0] device_address,
	output logic [7:0]  new_stack_pointer,
	output logic        error
);

	localparam int AW = $clog2(RAM_DEPTH);
	localparam logic [17:0] DEPTH_W = 18'(RAM_DEPTH);

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_B    = 2'd2;
	localparam logic [1:0] ST_W1   = 2'd3;

	function automatic logic [AW-1:0] ram_idx(input logic [12:0] a);
		logic [17:0] r;
		r = {5'b0, a};
		for (int k = 4; k >= 0; k--) begin
			if (r >= (DEPTH_W << k)) begin
				r = r - (DEPTH_W << k);
			end
		end
		return r[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] stack_idx(input logic [7:0] p);
		return ram_idx({cbdrs_pkg::STACK_PAGE_HI, p});
	endfunction

	logic [1:0]    state_q;
	logic [1:0]    state_nxt;
	logic [AW-1:0] clr_cnt_q;
	logic          accept;

	logic [2:0]  mode_q;
	logic [15:0] addr_q;
	logic [15:0] data_q;
	logic [7:0]  sp_q;
	logic [7:0]  lo_q;

	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;

	logic               done_q;
	logic [15:0]        read_data_q;
	logic [2:0]         target_q;
	logic [15:0]        dev_q;
	logic [7:0]         nsp_q;
	logic               error_q;
	cbdrs_pkg::route_t  rt;
	logic [15:0]        res_rd;
	logic [2:0]         res_tgt;
	logic [15:0]        res_dev;
	logic [7:0]         res_nsp;
	logic               res_err;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	cbdrs_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_cnt_q;
			end
			ST_IDLE: begin
				if (accept) begin
					case (mode)
						cbdrs_pkg::MODE_READ: begin
							mem_re   = (address < cbdrs_pkg::ADDR_PICTURE);
							mem_addr = ram_idx(address[12:0]);
						end
						cbdrs_pkg::MODE_WRITE: begin
							mem_we    = (address < cbdrs_pkg::ADDR_PICTURE);
							mem_addr  = ram_idx(address[12:0]);
							mem_wdata = data[7:0];
						end
						cbdrs_pkg::MODE_PUSH_BYTE: begin
							mem_we    = 1'b1;
							mem_addr  = stack_idx(stack_pointer);
							mem_wdata = data[7:0];
						end
						cbdrs_pkg::MODE_PUSH_WORD: begin
							mem_we    = 1'b1;
							mem_addr  = stack_idx(stack_pointer);
							mem_wdata = data[15:8];
						end
						cbdrs_pkg::MODE_POP_BYTE, cbdrs_pkg::MODE_POP_WORD: begin
							mem_re   = 1'b1;
							mem_addr = stack_idx(stack_pointer + 8'd1);
						end
						default: begin
						end
					endcase
				end
			end
			ST_W1: begin
				if (mode_q == cbdrs_pkg::MODE_PUSH_WORD) begin
					mem_we    = 1'b1;
					mem_addr  = stack_idx(sp_q - 8'd1);
					mem_wdata = data_q[7:0];
				end else begin
					mem_re   = 1'b1;
					mem_addr = stack_idx(sp_q + 8'd2);
				end
			end
			ST_B: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (clr_cnt_q == AW'(RAM_DEPTH - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (mode) inside
						cbdrs_pkg::MODE_PUSH_WORD, cbdrs_pkg::MODE_POP_WORD: state_nxt = ST_W1;
						default: state_nxt = ST_B;
					endcase
				end
			end
			ST_W1: state_nxt = ST_B;
			ST_B: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == ST_B);
			if (state_q == ST_CLR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			addr_q <= address;
			data_q <= data;
			sp_q   <= stack_pointer;
		end
		if (state_q == ST_W1) begin
			lo_q <= mem_rdata;
		end
		if (state_q == ST_B) begin
			read_data_q <= res_rd;
			target_q    <= res_tgt;
			dev_q       <= res_dev;
			nsp_q       <= res_nsp;
			error_q     <= res_err;
		end
	end

	assign rt = cbdrs_pkg::route(addr_q, mode_q == cbdrs_pkg::MODE_WRITE);

	always_comb begin
		res_rd  = '0;
		res_tgt = cbdrs_pkg::TGT_RAM;
		res_dev = '0;
		res_nsp = sp_q;
		res_err = 1'b0;
		case (mode_q)
			cbdrs_pkg::MODE_READ: begin
				res_tgt = rt.tgt;
				res_dev = rt.dev;
				res_err = rt.err;
				if (rt.tgt == cbdrs_pkg::TGT_RAM) begin
					res_rd = {8'h00, mem_rdata};
				end
			end
			cbdrs_pkg::MODE_WRITE: begin
				res_tgt = rt.tgt;
				res_dev = rt.dev;
				res_err = rt.err;
			end
			cbdrs_pkg::MODE_PUSH_BYTE: begin
				res_dev = {8'h01, sp_q};
				res_nsp = sp_q - 8'd1;
			end
			cbdrs_pkg::MODE_POP_BYTE: begin
				res_nsp = sp_q + 8'd1;
				res_dev = {8'h01, res_nsp};
				res_rd  = {8'h00, mem_rdata};
			end
			cbdrs_pkg::MODE_PUSH_WORD: begin
				res_dev = {8'h01, sp_q - 8'd1};
				res_nsp = sp_q - 8'd2;
			end
			cbdrs_pkg::MODE_POP_WORD: begin
				res_nsp = sp_q + 8'd2;
				res_dev = {8'h01, res_nsp};
				res_rd  = {mem_rdata, lo_q};
			end
			default: begin
				res_tgt = cbdrs_pkg::TGT_IGNORED;
				res_err = 1'b1;
			end
		endcase
	end

	assign done              = done_q;
	assign read_data         = read_data_q;
	assign target            = target_q;
	assign device_address    = dev_q;
	assign new_stack_pointer = nsp_q;
	assign error             = error_q;

	`CBDRS_ASSERT_NEXT(a_final_strobes, state_q == ST_B, done_q, "final cycle gave no strobe")
	`CBDRS_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q == ST_B || state_q == ST_W1, "accepted request not started")
	`CBDRS_ASSERT_NEXT(a_word_second_access, state_q == ST_W1, state_q == ST_B, "word request skipped its final cycle")
	`CBDRS_ASSERT_NOW(a_external_reads_zero, done_q && target_q != cbdrs_pkg::TGT_RAM, read_data_q == 16'h0000, "non-RAM result carries read data")

endmodule
